[hw/rtl/mp2x2_pkg.sv]
// Shared types, register indexes and helpers for the 2x2 stride-2 max pooling block.
// Used by mp2x2_front, mp2x2_back and max_pool_2x2_stream_top; depends on nothing.
package mp2x2_pkg;

	localparam int unsigned ACT_W      = 16;
	localparam int unsigned CHAN_W     = 4;
	localparam int unsigned COL_W      = 6;
	localparam int unsigned ROW_W      = 6;
	localparam int unsigned CFG_W      = 7;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned HEIGHT_CAP = 64;

	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 2'd2;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_STORE,
		CMD_EMIT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic signed [ACT_W-1:0]   value;
		logic        [CHAN_W-1:0]  channel;
		logic        [COL_W-1:0]   out_col;
		logic        [ROW_W-1:0]   out_row;
		logic                      frame_last;
	} cmd_t;

	typedef struct packed {
		logic signed [ACT_W-1:0]   pooled;
		logic        [CHAN_W-1:0]  channel;
		logic        [COL_W-1:0]   out_col;
		logic        [ROW_W-1:0]   out_row;
		logic                      frame_last;
	} result_t;

	function automatic logic signed [ACT_W-1:0] smax(
		input logic signed [ACT_W-1:0] a,
		input logic signed [ACT_W-1:0] b
	);
		return (a > b) ? a : b;
	endfunction

endpackage

[hw/rtl/mp2x2_fifo.sv]
// Small synchronous queue with push/full and pop/empty handshakes.
// Stand-alone; used for the command queue and the result queue of the pooling block.
module mp2x2_fifo #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [PW:0]      count_q;
	logic             wr;
	logic             rd;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign wr    = push & ~full;
	assign rd    = pop & ~empty;
	assign dout  = data_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			data_q[wptr_q] <= din;
		end
	end

endmodule

[hw/rtl/mp2x2_front.sv]
// Front end: configuration registers, stream position counters and classification
// of each beat into a hold, store or emit command. Depends on mp2x2_pkg.
module mp2x2_front #(
	parameter int unsigned MAX_OUT_WIDTH = 64,
	parameter int unsigned MAX_CHANNELS  = 16,
	parameter int unsigned CW            = 4,
	parameter int unsigned AW            = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mp2x2_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mp2x2_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                push,
	input  logic signed [mp2x2_pkg::ACT_W-1:0]  activation,
	input  logic                                cmd_full,
	output logic                                cmd_push,
	output mp2x2_pkg::cmd_t                     cmd,
	output logic [AW-1:0]                       cmd_addr,
	output logic [CW-1:0]                       cmd_cidx
);

	logic [6:0]    out_width_q;
	logic [6:0]    out_height_q;
	logic [4:0]    num_ch_q;
	logic [CW-1:0] chan_q;
	logic [7:0]    col_q;
	logic [6:0]    row_q;

	logic [6:0]    w_eff;
	logic [6:0]    h_eff;
	logic [4:0]    nc_eff;
	logic          chan_last;
	logic          col_last;
	logic          row_last;
	logic [6:0]    ox;

	always_comb begin
		if (out_width_q == '0) begin
			w_eff = 7'd1;
		end else if (int'(out_width_q) > MAX_OUT_WIDTH) begin
			w_eff = 7'(MAX_OUT_WIDTH);
		end else begin
			w_eff = out_width_q;
		end
		if (out_height_q == '0) begin
			h_eff = 7'd1;
		end else if (int'(out_height_q) > mp2x2_pkg::HEIGHT_CAP) begin
			h_eff = 7'(mp2x2_pkg::HEIGHT_CAP);
		end else begin
			h_eff = out_height_q;
		end
		if (num_ch_q == '0) begin
			nc_eff = 5'd1;
		end else if (int'(num_ch_q) > MAX_CHANNELS) begin
			nc_eff = 5'(MAX_CHANNELS);
		end else begin
			nc_eff = num_ch_q;
		end
	end

	assign chan_last = (9'(chan_q) + 9'd1) >= 9'(nc_eff);
	assign col_last  = (9'(col_q) + 9'd1) >= {1'b0, w_eff, 1'b0};
	assign row_last  = (8'(row_q) + 8'd1) >= {h_eff, 1'b0};
	assign ox        = col_q[7:1];

	assign cmd_push = push & ~cmd_full;
	assign cmd_cidx = chan_q;
	assign cmd_addr = AW'(AW'(ox) * AW'(MAX_CHANNELS) + AW'(chan_q));

	always_comb begin
		if (!col_q[0]) begin
			cmd.kind = mp2x2_pkg::CMD_HOLD;
		end else if (!row_q[0]) begin
			cmd.kind = mp2x2_pkg::CMD_STORE;
		end else begin
			cmd.kind = mp2x2_pkg::CMD_EMIT;
		end
		cmd.value      = activation;
		cmd.channel    = mp2x2_pkg::CHAN_W'(chan_q);
		cmd.out_col    = ox[5:0];
		cmd.out_row    = row_q[6:1];
		cmd.frame_last = chan_last & col_last & row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q  <= 7'd64;
			out_height_q <= 7'd64;
			num_ch_q     <= 5'd16;
			chan_q       <= '0;
			col_q        <= '0;
			row_q        <= '0;
		end else begin
			if (cmd_push) begin
				if (chan_last) begin
					chan_q <= '0;
					if (col_last) begin
						col_q <= '0;
						row_q <= row_last ? '0 : row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end else begin
					chan_q <= chan_q + 1'b1;
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					mp2x2_pkg::REG_OUT_WIDTH: begin
						out_width_q <= cfg_data;
						chan_q      <= '0;
						col_q       <= '0;
						row_q       <= '0;
					end
					mp2x2_pkg::REG_OUT_HEIGHT: begin
						out_height_q <= cfg_data;
						chan_q       <= '0;
						col_q        <= '0;
						row_q        <= '0;
					end
					mp2x2_pkg::REG_NUM_CHANNELS: begin
						num_ch_q <= cfg_data[4:0];
						chan_q   <= '0;
						col_q    <= '0;
						row_q    <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_idx == mp2x2_pkg::REG_OUT_WIDTH ||
			cfg_idx == mp2x2_pkg::REG_OUT_HEIGHT ||
			cfg_idx == mp2x2_pkg::REG_NUM_CHANNELS)
		|=> chan_q == '0 && col_q == '0 && row_q == '0)
		else $error("Register write did not restart the frame.");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd.frame_last |=> chan_q == '0 && col_q == '0 && row_q == '0)
		else $error("Position did not return to the frame origin after its last beat.");

endmodule

[hw/rtl/mp2x2_back.sv]
// Back end: per-channel pair hold, row line store and the two-stage emit path.
// Depends on mp2x2_pkg; fed by the command queue, feeds the result queue.
module mp2x2_back #(
	parameter int unsigned MAX_OUT_WIDTH = 64,
	parameter int unsigned MAX_CHANNELS  = 16,
	parameter int unsigned CW            = 4,
	parameter int unsigned AW            = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  mp2x2_pkg::cmd_t    cmd,
	input  logic [AW-1:0]      cmd_addr,
	input  logic [CW-1:0]      cmd_cidx,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output mp2x2_pkg::result_t res
);

	localparam int unsigned DEPTH = MAX_OUT_WIDTH * MAX_CHANNELS;

	logic signed [mp2x2_pkg::ACT_W-1:0] hold_q  [MAX_CHANNELS];
	logic signed [mp2x2_pkg::ACT_W-1:0] row_mem [DEPTH];

	logic signed [mp2x2_pkg::ACT_W-1:0] rd_s2;
	logic signed [mp2x2_pkg::ACT_W-1:0] m_s2;
	mp2x2_pkg::cmd_t                    cmd_s2;
	logic                               emit_s2;

	logic signed [mp2x2_pkg::ACT_W-1:0] m_s1;
	logic                               s2_go;
	logic                               s2_free;

	assign m_s1     = mp2x2_pkg::smax(hold_q[cmd_cidx], cmd.value);
	assign s2_go    = emit_s2 & ~res_full;
	assign s2_free  = ~emit_s2 | ~res_full;
	assign cmd_pop  = cmd_valid & ((cmd.kind != mp2x2_pkg::CMD_EMIT) | s2_free);
	assign res_push = s2_go;

	always_comb begin
		res.pooled     = mp2x2_pkg::smax(rd_s2, m_s2);
		res.channel    = cmd_s2.channel;
		res.out_col    = cmd_s2.out_col;
		res.out_row    = cmd_s2.out_row;
		res.frame_last = cmd_s2.frame_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else if (cmd_pop && cmd.kind == mp2x2_pkg::CMD_EMIT) begin
			emit_s2 <= 1'b1;
		end else if (s2_go) begin
			emit_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			case (cmd.kind)
				mp2x2_pkg::CMD_HOLD: begin
					hold_q[cmd_cidx] <= cmd.value;
				end
				mp2x2_pkg::CMD_STORE: begin
					row_mem[cmd_addr] <= m_s1;
				end
				mp2x2_pkg::CMD_EMIT: begin
					rd_s2  <= row_mem[cmd_addr];
					m_s2   <= m_s1;
					cmd_s2 <= cmd;
				end
				default: begin
				end
			endcase
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		emit_s2 && res_full |=> emit_s2 && $stable(rd_s2) && $stable(m_s2))
		else $error("Pending window result changed while the result queue was full.");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("Command taken from an empty queue.");

endmodule

[hw/rtl/max_pool_2x2_stream_top.sv]
// Channel   | Direction | Handshake          | Beat contents
// input     | in        | push / full        | activation
// result    | out       | empty / pop        | pooled, channel, out_col, out_row, frame_last
// config    | in        | cfg_we             | cfg_idx, cfg_data
//
// One input beat per cycle and one result beat per cycle are sustained while the result side keeps popping.
// A result passes, after the beat carrying its window's bottom-right value, through the
// command queue, the line-store read stage and the result queue.
// Reset sets the registers to 64 x 64 outputs and 16 channels and the position to the origin;
// the line store and pair hold are not cleared, so the block takes beats right after reset.
// A stalled result side fills the result queue, then the emit stage, then the command
// queue, after which full rises; hold and store beats drain until an emit command heads the queue.
module max_pool_2x2_stream_top #(
	parameter int unsigned MAX_OUT_WIDTH = 64,
	parameter int unsigned MAX_CHANNELS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mp2x2_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mp2x2_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic signed [mp2x2_pkg::ACT_W-1:0]  activation,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [mp2x2_pkg::ACT_W-1:0]  pooled,
	output logic [mp2x2_pkg::CHAN_W-1:0]        channel,
	output logic [mp2x2_pkg::COL_W-1:0]         out_col,
	output logic [mp2x2_pkg::ROW_W-1:0]         out_row,
	output logic                                frame_last
);

	localparam int unsigned CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int unsigned AW    = (MAX_OUT_WIDTH * MAX_CHANNELS > 1) ?
		$clog2(MAX_OUT_WIDTH * MAX_CHANNELS) : 1;
	localparam int unsigned CQ_W  = $bits(mp2x2_pkg::cmd_t) + AW + CW;
	localparam int unsigned RQ_W  = $bits(mp2x2_pkg::result_t);
	localparam int unsigned Q_DEPTH = 4;

	mp2x2_pkg::cmd_t    f_cmd;
	logic [AW-1:0]      f_addr;
	logic [CW-1:0]      f_cidx;
	logic               f_push;

	mp2x2_pkg::cmd_t    b_cmd;
	logic [AW-1:0]      b_addr;
	logic [CW-1:0]      b_cidx;
	logic               b_pop;
	logic               cq_empty;
	logic [CQ_W-1:0]    cq_dout;

	mp2x2_pkg::result_t b_res;
	logic               b_res_push;
	logic               rq_full;
	logic [RQ_W-1:0]    rq_dout;
	mp2x2_pkg::result_t rq_res;

	mp2x2_front #(
		.MAX_OUT_WIDTH(MAX_OUT_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS),
		.CW           (CW),
		.AW           (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.push      (push),
		.activation(activation),
		.cmd_full  (full),
		.cmd_push  (f_push),
		.cmd       (f_cmd),
		.cmd_addr  (f_addr),
		.cmd_cidx  (f_cidx)
	);

	mp2x2_fifo #(
		.WIDTH(CQ_W),
		.DEPTH(Q_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.din   ({f_cmd, f_addr, f_cidx}),
		.full  (full),
		.pop   (b_pop),
		.dout  (cq_dout),
		.empty (cq_empty)
	);

	assign {b_cmd, b_addr, b_cidx} = cq_dout;

	mp2x2_back #(
		.MAX_OUT_WIDTH(MAX_OUT_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS),
		.CW           (CW),
		.AW           (AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(~cq_empty),
		.cmd      (b_cmd),
		.cmd_addr (b_addr),
		.cmd_cidx (b_cidx),
		.cmd_pop  (b_pop),
		.res_full (rq_full),
		.res_push (b_res_push),
		.res      (b_res)
	);

	mp2x2_fifo #(
		.WIDTH(RQ_W),
		.DEPTH(Q_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (b_res_push),
		.din   (b_res),
		.full  (rq_full),
		.pop   (pop),
		.dout  (rq_dout),
		.empty (empty)
	);

	assign rq_res     = rq_dout;
	assign pooled     = rq_res.pooled;
	assign channel    = rq_res.channel;
	assign out_col    = rq_res.out_col;
	assign out_row    = rq_res.out_row;
	assign frame_last = rq_res.frame_last;

endmodule

[tb/max_pool_2x2_stream_top_test.sv]
// Self-checking testbench for max_pool_2x2_stream_top: 2x2 stride-2 max pooling of a
// channel-interleaved activation stream, checked against an in-bench window predictor.
// Depends on mp2x2_pkg and max_pool_2x2_stream_top only.
`timescale 1ns / 1ps

class pool_scoreboard;
	localparam int unsigned LINE_COLS  = 64;
	localparam int unsigned LINE_CHANS = 16;

	logic [6:0] width_reg;
	logic [6:0] height_reg;
	logic [4:0] chan_reg;
	logic signed [15:0] line_max [LINE_COLS*LINE_CHANS];
	logic signed [15:0] pair_first [LINE_CHANS];
	int unsigned chan_pos;
	int unsigned col_pos;
	int unsigned row_pos;
	mp2x2_pkg::result_t windows_due [$];
	int unsigned mismatches;

	function new();
		width_reg = 7'd64;
		height_reg = 7'd64;
		chan_reg = 5'd16;
		foreach (line_max[i]) line_max[i] = '0;
		foreach (pair_first[i]) pair_first[i] = '0;
		chan_pos = 0;
		col_pos = 0;
		row_pos = 0;
		mismatches = 0;
	endfunction

	static function int unsigned in_range(int unsigned v, int unsigned cap);
		if (v == 0) return 1;
		if (v > cap) return cap;
		return v;
	endfunction

	function void set_register(logic [1:0] idx, logic [6:0] data);
		case (idx)
			mp2x2_pkg::REG_OUT_WIDTH: width_reg = data;
			mp2x2_pkg::REG_OUT_HEIGHT: height_reg = data;
			mp2x2_pkg::REG_NUM_CHANNELS: chan_reg = data[4:0];
			default: return;
		endcase
		chan_pos = 0;
		col_pos = 0;
		row_pos = 0;
	endfunction

	function void note_activation(logic signed [15:0] v);
		int unsigned w;
		int unsigned h;
		int unsigned nc;
		int unsigned c;
		int unsigned ox;
		int unsigned slot;
		logic signed [15:0] pair_max;
		logic signed [15:0] window_max;
		mp2x2_pkg::result_t due;
		w = in_range(width_reg, LINE_COLS);
		h = in_range(height_reg, mp2x2_pkg::HEIGHT_CAP);
		nc = in_range(chan_reg, LINE_CHANS);
		c = (chan_pos >= nc) ? nc - 1 : chan_pos;
		ox = ((col_pos >> 1) >= w) ? w - 1 : (col_pos >> 1);
		if (col_pos % 2 == 0) begin
			pair_first[c] = v;
		end else begin
			pair_max = (pair_first[c] > v) ? pair_first[c] : v;
			slot = ox * LINE_CHANS + c;
			if (row_pos % 2 == 0) begin
				line_max[slot] = pair_max;
			end else begin
				window_max = (line_max[slot] > pair_max) ? line_max[slot] : pair_max;
				due.pooled = window_max;
				due.channel = 4'(c);
				due.out_col = 6'(ox);
				due.out_row = 6'(row_pos >> 1);
				due.frame_last = (c == nc - 1) && (col_pos + 1 >= 2 * w) &&
					(row_pos + 1 >= 2 * h);
				windows_due.push_back(due);
			end
		end
		chan_pos++;
		if (chan_pos >= nc) begin
			chan_pos = 0;
			col_pos++;
			if (col_pos >= 2 * w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= 2 * h) row_pos = 0;
			end
		end
	endfunction

	function void check_window(mp2x2_pkg::result_t got);
		mp2x2_pkg::result_t want;
		if (windows_due.size() == 0) begin
			mismatches++;
			$display("%0t: result beat with no window due: pooled %0d ch %0d col %0d row %0d last %0b",
				$time, $signed(got.pooled), got.channel, got.out_col, got.out_row,
				got.frame_last);
			return;
		end
		want = windows_due.pop_front();
		if (got !== want) begin
			mismatches++;
			$display("%0t: window mismatch: expected pooled %0d ch %0d col %0d row %0d last %0b",
				$time, $signed(want.pooled), want.channel, want.out_col, want.out_row,
				want.frame_last);
			$display("%0t:                  actual pooled %0d ch %0d col %0d row %0d last %0b",
				$time, $signed(got.pooled), got.channel, got.out_col, got.out_row,
				got.frame_last);
		end
	endfunction
endclass

module max_pool_2x2_stream_top_test;

	localparam logic [mp2x2_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned LONG_HOLD     = 300;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT   = 100000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [mp2x2_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [mp2x2_pkg::CFG_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic signed [mp2x2_pkg::ACT_W-1:0] activation = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [mp2x2_pkg::ACT_W-1:0] pooled;
	logic [mp2x2_pkg::CHAN_W-1:0] channel;
	logic [mp2x2_pkg::COL_W-1:0] out_col;
	logic [mp2x2_pkg::ROW_W-1:0] out_row;
	logic frame_last;

	pool_scoreboard board;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;

	max_pool_2x2_stream_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.activation(activation),
		.empty(empty),
		.pop(pop),
		.pooled(pooled),
		.channel(channel),
		.out_col(out_col),
		.out_row(out_row),
		.frame_last(frame_last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin : result_side
		mp2x2_pkg::result_t got;
		if (arst_n && pop && !empty) begin
			got.pooled = pooled;
			got.channel = channel;
			got.out_col = out_col;
			got.out_row = out_row;
			got.frame_last = frame_last;
			board.check_window(got);
		end
		if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_left <= LONG_HOLD;
			pop <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic signed [mp2x2_pkg::ACT_W-1:0] pick_activation();
		case ($urandom_range(15))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			4: return 16'($urandom_range(3));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_activation(input logic signed [mp2x2_pkg::ACT_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		activation <= v;
		do @(posedge clk); while (full);
		board.note_activation(v);
	endtask

	task automatic hold_input_until_drained();
		push <= 1'b0;
		do @(posedge clk); while (board.windows_due.size() != 0);
	endtask

	task automatic settle();
		hold_input_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mp2x2_pkg::CFG_IDX_W-1:0] idx,
			input logic [mp2x2_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.set_register(idx, data);
	endtask

	task automatic configure(input logic [mp2x2_pkg::CFG_W-1:0] w,
			input logic [mp2x2_pkg::CFG_W-1:0] h, input logic [mp2x2_pkg::CFG_W-1:0] nc);
		write_reg(mp2x2_pkg::REG_OUT_WIDTH, w);
		write_reg(mp2x2_pkg::REG_OUT_HEIGHT, h);
		write_reg(mp2x2_pkg::REG_NUM_CHANNELS, nc);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned count;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One-window frames: field extremes, frame wrap, and a write to the unused index.
		configure(7'd1, 7'd1, 7'd1);
		send_activation(16'sh8000);
		send_activation(16'sh7FFF);
		send_activation(16'shFFFF);
		send_activation(16'sh0000);
		send_activation(16'shFFFE);
		send_activation(16'shFFFD);
		settle();
		write_reg(REG_SPARE, 7'h7F);
		cfg_we <= 1'b0;
		send_activation(16'shFFFF);
		send_activation(16'shFFFC);

		// A register write in the middle of a frame restarts it; zero acts as one.
		send_activation(16'sh0064);
		send_activation(16'sh00C8);
		send_activation(16'sh012C);
		settle();
		configure(7'd0, 7'd0, 7'd0);
		send_activation(16'sh0007);
		send_activation(16'shFFF9);
		send_activation(16'sh0008);
		send_activation(16'sh0009);

		settle();
		configure(7'd1, 7'd1, 7'd2);
		send_activation(16'sh8000);
		send_activation(16'sh7FFF);
		send_activation(16'sh8001);
		send_activation(16'sh7FFE);
		send_activation(16'sh8000);
		send_activation(16'sh0000);
		send_activation(16'sh8000);
		send_activation(16'sh7FFF);

		for (int p = 0; p < 8; p++) begin
			settle();
			send_idle_pct = (p % 4 == 1) ? 86 : (p % 4 == 3) ? 12 : 0;
			recv_stall_pct <= (p % 4 == 2) ? 86 : (p % 4 == 3) ? 12 : 0;
			case (p)
				0: begin
					configure(7'd127, 7'd0, 7'd0);
					count = 132;
				end
				1: begin
					configure(7'd1, 7'd100, 7'd1);
					count = 256;
				end
				2: begin
					configure(7'd1, 7'd1, 7'h7F);
					count = 64;
				end
				3: begin
					configure(7'd64, 7'd64, 7'd16);
					count = 48;
				end
				4: begin
					configure(7'd1, 7'd1, 7'd1);
					hold_requests <= hold_requests + 1;
					count = 80;
				end
				default: begin
					configure(7'($urandom_range(6)), 7'($urandom_range(4)),
						{2'($urandom_range(3)), 5'($urandom_range(4))});
					count = 40;
				end
			endcase
			for (int i = 0; i < count; i++) begin
				if (p == 5 && i == count / 2) hold_input_until_drained();
				send_activation(pick_activation());
			end
		end

		settle();
		if (board.mismatches == 0 && board.windows_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/mp2x2_pkg.sv
hw/rtl/mp2x2_fifo.sv
hw/rtl/mp2x2_front.sv
hw/rtl/mp2x2_back.sv
hw/rtl/max_pool_2x2_stream_top.sv
tb/max_pool_2x2_stream_top_test.sv
